// ===== rtl/core/wgr_pkg.sv =====
// Shared constants and types of the word graph reachability block.
package wgr_pkg;

    // Default sizes of the stores
    localparam int WGR_MAX_WORDS   = 64;
    localparam int WGR_MAX_CHARS   = 8;
    localparam int WGR_STACK_DEPTH = 2048;

    // Fixed field widths of the channels
    localparam int WGR_OP_W    = 2;
    localparam int WGR_CHARS_W = 64;
    localparam int WGR_LEN_W   = 4;
    localparam int WGR_IDX_W   = 6;

    // Command codes
    typedef enum logic [WGR_OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } t_opcode;

endpackage

// ===== rtl/core/wgr_near.sv =====
// Shared compare unit: two words are near when lengths match and at most one byte differs.
module wgr_near #(
    parameter int MAX_CHARS = wgr_pkg::WGR_MAX_CHARS
) (
    input  logic [MAX_CHARS*8-1:0]       i_a_chars,
    input  logic [wgr_pkg::WGR_LEN_W-1:0] i_a_len,
    input  logic [MAX_CHARS*8-1:0]       i_b_chars,
    input  logic [wgr_pkg::WGR_LEN_W-1:0] i_b_len,
    output logic                         o_near
);
    import wgr_pkg::*;

    logic [MAX_CHARS-1:0] diff;

    // Per-byte mismatch; bytes past the length are stored as zero on both sides
    always_comb begin
        for (int j = 0; j < MAX_CHARS; j++) begin
            diff[j] = (i_a_chars[j*8 +: 8] != i_b_chars[j*8 +: 8]);
        end
    end

    // At most one mismatch: clearing the lowest set bit leaves nothing
    assign o_near = (i_a_len == i_b_len) && ((diff & (diff - 1'b1)) == '0);

endmodule

// ===== rtl/core/wgr_stack.sv =====
// Walk stack memory: one write port and one registered read port.
module wgr_stack #(
    parameter int DEPTH = wgr_pkg::WGR_STACK_DEPTH,
    parameter int DW    = wgr_pkg::WGR_IDX_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    import wgr_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/core/word_graph_reachability.sv =====
// Top level of the word graph reachability block: sequencer, stores and result register.
//
// Input channel (i_in_valid / o_in_stall) takes one command per transfer:
//   clear empties the store, add appends a word and links it
//   to every stored word of equal length that differs in at most one byte,
//   query walks the graph depth first from i_start_index.
// Output channel (o_out_valid / i_out_stall) gives one transfer per reached
// word in visit order, o_last on the final one; a bad start index gives a
// single transfer with o_found low.
// The block takes one command at a time and stalls its input until the
// command is finished. An add reads and then compares each stored word in
// turn, set by the single read port of the word and adjacency memories
// feeding the one compare unit. A query pops, checks, emits and pushes for
// each visited word, one push step per neighbor, and pops and checks each
// stale stack entry, set by the one stack port and the one adjacency read
// per visit. Once the walk finds the stack empty, the done state loads the last result.
// A stalled receiver holds the result register; the walk waits at the next
// result while the register and the one-entry holding stage are full.
// Reset empties the store and clears the walk and the result register.
module word_graph_reachability #(
    parameter int MAX_WORDS   = wgr_pkg::WGR_MAX_WORDS,
    parameter int MAX_CHARS   = wgr_pkg::WGR_MAX_CHARS,
    parameter int STACK_DEPTH = wgr_pkg::WGR_STACK_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [wgr_pkg::WGR_OP_W-1:0]    i_opcode,
    input  logic [wgr_pkg::WGR_CHARS_W-1:0] i_word_chars,
    input  logic [wgr_pkg::WGR_LEN_W-1:0]   i_word_length,
    input  logic [wgr_pkg::WGR_IDX_W-1:0]   i_start_index,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_found,
    output logic [wgr_pkg::WGR_IDX_W-1:0]   o_vertex_index,
    output logic [wgr_pkg::WGR_CHARS_W-1:0] o_reached_chars,
    output logic [wgr_pkg::WGR_LEN_W-1:0]   o_reached_length,
    output logic                            o_last
);
    import wgr_pkg::*;

    localparam int IW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW  = $clog2(MAX_WORDS + 1);
    localparam int CHW = MAX_CHARS * 8;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int XW  = WGR_IDX_W + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ARD   = 10'b0000000010,
        S_ACMP  = 10'b0000000100,
        S_AFIN  = 10'b0000001000,
        S_POP   = 10'b0000010000,
        S_CHK   = 10'b0000100000,
        S_EMIT  = 10'b0001000000,
        S_PUSH  = 10'b0010000000,
        S_DONE  = 10'b0100000000,
        S_BAD   = 10'b1000000000
    } t_state;

    // Control state
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [MAX_WORDS-1:0] r_row_valid;
    logic [IW-1:0]        r_idx, n_idx;
    logic [MAX_WORDS-1:0] r_vis, n_vis;
    logic [SPW-1:0]       r_sp, n_sp;
    logic                 r_pend_v, n_pend_v;
    logic                 r_ov, n_ov;

    // Payload
    logic [CHW-1:0]       r_new_chars, n_new_chars;
    logic [WGR_LEN_W-1:0] r_new_len, n_new_len;
    logic [MAX_WORDS-1:0] r_new_row, n_new_row;
    logic [IW-1:0]        r_cur, n_cur;
    logic [MAX_WORDS-1:0] r_mask, n_mask;
    logic [IW-1:0]        r_pend_idx, n_pend_idx;
    logic [CHW-1:0]       r_pend_chars, n_pend_chars;
    logic [WGR_LEN_W-1:0] r_pend_len, n_pend_len;
    logic                 r_o_found, n_o_found;
    logic [IW-1:0]        r_o_idx, n_o_idx;
    logic [CHW-1:0]       r_o_chars, n_o_chars;
    logic [WGR_LEN_W-1:0] r_o_len, n_o_len;
    logic                 r_o_last, n_o_last;

    // Stores
    logic [CHW-1:0]       r_word_mem [MAX_WORDS];
    logic [WGR_LEN_W-1:0] r_len_mem  [MAX_WORDS];
    logic [MAX_WORDS-1:0] r_adj_mem  [MAX_WORDS];
    logic [CHW-1:0]       r_word_q;
    logic [WGR_LEN_W-1:0] r_len_q;
    logic [MAX_WORDS-1:0] r_adj_q;
    logic                 r_rowv_q;

    // Strobes
    logic                 in_xfer, out_free, clear_rows, set_row;
    logic                 mem_re, word_we, adj_we;
    logic [IW-1:0]        rd_addr, adj_waddr, new_slot;
    logic [MAX_WORDS-1:0] adj_wdata, row_eff, cnt_mask, low_bit;
    logic [IW-1:0]        low_idx;
    logic                 near;
    logic                 stk_we, stk_re;
    logic [AW-1:0]        stk_waddr, stk_raddr;
    logic [IW-1:0]        stk_wdata, stk_q;
    logic [WGR_LEN_W-1:0] sat_len;
    logic [CHW-1:0]       kept_chars;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign new_slot   = IW'(r_count);
    assign row_eff    = r_rowv_q ? r_adj_q : '0;

    // Length saturation and dropping of stray bytes
    always_comb begin
        sat_len = (i_word_length > WGR_LEN_W'(MAX_CHARS)) ? WGR_LEN_W'(MAX_CHARS)
                                                          : i_word_length;
        for (int j = 0; j < MAX_CHARS; j++) begin
            kept_chars[j*8 +: 8] = (WGR_LEN_W'(j) < sat_len) ? i_word_chars[j*8 +: 8] : 8'h00;
        end
    end

    // Stored-word mask and lowest pending neighbor
    always_comb begin
        for (int i = 0; i < MAX_WORDS; i++) begin
            cnt_mask[i] = (CW'(i) < r_count);
        end
        low_bit = r_mask & (~r_mask + 1'b1);
        low_idx = '0;
        for (int i = 0; i < MAX_WORDS; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | IW'(i);
            end
        end
    end

    wgr_near #(
        .MAX_CHARS (MAX_CHARS)
    ) u_near (
        .i_a_chars (r_word_q),
        .i_a_len   (r_len_q),
        .i_b_chars (r_new_chars),
        .i_b_len   (r_new_len),
        .o_near    (near)
    );

    wgr_stack #(
        .DEPTH (STACK_DEPTH),
        .DW    (IW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_vis        = r_vis;
        n_sp         = r_sp;
        n_pend_v     = r_pend_v;
        n_ov         = r_ov && i_out_stall;
        n_new_chars  = r_new_chars;
        n_new_len    = r_new_len;
        n_new_row    = r_new_row;
        n_cur        = r_cur;
        n_mask       = r_mask;
        n_pend_idx   = r_pend_idx;
        n_pend_chars = r_pend_chars;
        n_pend_len   = r_pend_len;
        n_o_found    = r_o_found;
        n_o_idx      = r_o_idx;
        n_o_chars    = r_o_chars;
        n_o_len      = r_o_len;
        n_o_last     = r_o_last;
        clear_rows   = 1'b0;
        set_row      = 1'b0;
        mem_re       = 1'b0;
        rd_addr      = r_idx;
        word_we      = 1'b0;
        adj_we       = 1'b0;
        adj_waddr    = r_idx;
        adj_wdata    = row_eff | (MAX_WORDS'(1) << r_count);
        stk_we       = 1'b0;
        stk_waddr    = AW'(r_sp);
        stk_wdata    = low_idx;
        stk_re       = 1'b0;
        stk_raddr    = AW'(r_sp - 1'b1);

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (t_opcode'(i_opcode))
                        OP_CLEAR: begin
                            n_count    = '0;
                            clear_rows = 1'b1;
                        end
                        OP_ADD: begin
                            if (r_count < CW'(MAX_WORDS)) begin
                                n_new_chars = kept_chars;
                                n_new_len   = sat_len;
                                n_new_row   = '0;
                                n_idx       = '0;
                                n_state     = (r_count == '0) ? S_AFIN : S_ARD;
                            end
                        end
                        OP_QUERY: begin
                            if (XW'(i_start_index) >= XW'(r_count)) begin
                                n_state = S_BAD;
                            end else begin
                                n_vis     = '0;
                                stk_we    = 1'b1;
                                stk_waddr = '0;
                                stk_wdata = IW'(i_start_index);
                                n_sp      = SPW'(1);
                                n_state   = S_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ARD: begin
                mem_re  = 1'b1;
                rd_addr = r_idx;
                n_state = S_ACMP;
            end
            S_ACMP: begin
                if (near) begin
                    adj_we    = 1'b1;
                    adj_waddr = r_idx;
                    n_new_row = r_new_row | (MAX_WORDS'(1) << r_idx);
                end
                if (CW'(r_idx) + 1'b1 == r_count) begin
                    n_state = S_AFIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_ARD;
                end
            end
            S_AFIN: begin
                word_we   = 1'b1;
                adj_we    = 1'b1;
                adj_waddr = new_slot;
                adj_wdata = r_new_row;
                set_row   = 1'b1;
                n_count   = r_count + 1'b1;
                n_state   = S_IDLE;
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_DONE;
                end else begin
                    stk_re  = 1'b1;
                    n_sp    = r_sp - 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_vis[stk_q]) begin
                    n_state = S_POP;
                end else begin
                    n_vis          = r_vis | (MAX_WORDS'(1) << stk_q);
                    n_cur          = stk_q;
                    mem_re         = 1'b1;
                    rd_addr        = stk_q;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                // Previous visit leaves the holding stage when the new one arrives
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_ov      = 1'b1;
                        n_o_found = 1'b1;
                        n_o_idx   = r_pend_idx;
                        n_o_chars = r_pend_chars;
                        n_o_len   = r_pend_len;
                        n_o_last  = 1'b0;
                    end
                    n_pend_v     = 1'b1;
                    n_pend_idx   = r_cur;
                    n_pend_chars = r_word_q;
                    n_pend_len   = r_len_q;
                    n_mask       = row_eff & ~r_vis & cnt_mask;
                    n_state      = S_PUSH;
                end
            end
            S_PUSH: begin
                // One neighbor per cycle, lowest index first; a full stack drops it
                if (r_mask == '0) begin
                    n_state = S_POP;
                end else begin
                    if (r_sp < SPW'(STACK_DEPTH)) begin
                        stk_we = 1'b1;
                        n_sp   = r_sp + 1'b1;
                    end
                    n_mask = r_mask & ~low_bit;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_found = 1'b1;
                    n_o_idx   = r_pend_idx;
                    n_o_chars = r_pend_chars;
                    n_o_len   = r_pend_len;
                    n_o_last  = 1'b1;
                    n_pend_v  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_BAD: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_o_found = 1'b0;
                    n_o_idx   = '0;
                    n_o_chars = '0;
                    n_o_len   = '0;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_vis    <= '0;
            r_sp     <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_vis    <= n_vis;
            r_sp     <= n_sp;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    // Row valid bits: an invalid adjacency row reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_rows) begin
            r_row_valid <= '0;
        end else if (set_row) begin
            r_row_valid[new_slot] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_new_chars  <= n_new_chars;
        r_new_len    <= n_new_len;
        r_new_row    <= n_new_row;
        r_cur        <= n_cur;
        r_mask       <= n_mask;
        r_pend_idx   <= n_pend_idx;
        r_pend_chars <= n_pend_chars;
        r_pend_len   <= n_pend_len;
        r_o_found    <= n_o_found;
        r_o_idx      <= n_o_idx;
        r_o_chars    <= n_o_chars;
        r_o_len      <= n_o_len;
        r_o_last     <= n_o_last;
    end

    // Store writes
    always_ff @(posedge i_clk) begin
        if (word_we) begin
            r_word_mem[new_slot] <= r_new_chars;
            r_len_mem[new_slot]  <= r_new_len;
        end
        if (adj_we) begin
            r_adj_mem[adj_waddr] <= adj_wdata;
        end
    end

    // Store reads, registered
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_word_q <= r_word_mem[rd_addr];
            r_len_q  <= r_len_mem[rd_addr];
            r_adj_q  <= r_adj_mem[rd_addr];
            r_rowv_q <= r_row_valid[rd_addr];
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_found          = r_o_found;
    assign o_vertex_index   = WGR_IDX_W'(r_o_idx);
    assign o_reached_chars  = WGR_CHARS_W'(r_o_chars);
    assign o_reached_length = r_o_len;
    assign o_last           = r_o_last;

`ifndef SYNTH
    // Stack pointer never passes the stack size
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("walk stack pointer out of range");

    // Word count never passes the store size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_WORDS))
        else $error("word count out of range");

    // Neighbors are pushed only after the current word is marked
    a_push_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> r_vis[r_cur])
        else $error("pushing neighbors of an unmarked word");

    // Nothing is held back once the block is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("held result left behind");

    // Pending neighbors are never already visited
    a_mask_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> ((r_mask & r_vis) == '0))
        else $error("visited word queued for push");
`endif

endmodule
